@@ sv/sact_pkg.sv @@
package sact_pkg;

    localparam int ADDR_W    = 48;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [2:0] OP_ACCESS  = 3'd0;
    localparam logic [2:0] OP_INSTALL = 3'd1;
    localparam logic [2:0] OP_PROBE   = 3'd2;
    localparam logic [2:0] OP_INVAL   = 3'd3;
    localparam logic [2:0] OP_CLEAN   = 3'd4;

    localparam logic [2:0] POL_LRU   = 3'd0;
    localparam logic [2:0] POL_PLRU  = 3'd1;
    localparam logic [2:0] POL_RAND  = 3'd2;
    localparam logic [2:0] POL_SRRIP = 3'd3;
    localparam logic [2:0] POL_BRRIP = 3'd4;

    localparam logic [1:0] RES_HIT        = 2'd0;
    localparam logic [1:0] RES_MISS       = 2'd1;
    localparam logic [1:0] RES_MISS_DIRTY = 2'd2;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_INDEX  = 2'd2;
    localparam logic [1:0] CFG_SEED   = 2'd3;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [1:0] RRIP_MAX  = 2'd3;
    localparam logic [1:0] RRIP_LONG = 2'd2;
    localparam logic [4:0] BRRIP_MASK_ZERO = 5'd0;
    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(1);

    typedef struct packed {
        logic [2:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic              write_flag;
    } t_in;

    typedef struct packed {
        logic [1:0]        outcome;
        logic              line_found;
        logic              dirty_seen;
        logic [ADDR_W-1:0] evicted_address;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOOK,
        S_SCAN,
        S_MOD,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             read;
        logic             look;
        logic             scan;
        logic             modstep;
        logic             commit;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic need_mod;
        logic out_free;
    } t_status;

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        logic [31:0] r;
        r = v >> 1;
        if (v[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

@@ sv/sact_ctrl.sv @@
module sact_ctrl import sact_pkg::*; #(
    parameter int WAYS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WAYS - 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (i_st.need_mod) begin
                    n_state = S_MOD;
                    n_cnt   = '0;
                end else if (i_st.need_scan) begin
                    n_state = S_SCAN;
                    n_cnt   = CNT_W'(1);
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == SCAN_LAST) begin
                    n_state = S_COMMIT;
                end
            end
            S_MOD: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == MOD_LAST) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd         = '0;
        o_cmd.idx     = r_cnt;
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.read    = (r_state == S_READ);
        o_cmd.look    = (r_state == S_LOOK);
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.modstep = (r_state == S_MOD);
        o_cmd.commit  = (r_state == S_COMMIT) && i_st.out_free;
    end

endmodule

@@ sv/sact_dp.sv @@
module sact_dp import sact_pkg::*; #(
    parameter int SETS      = 64,
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in                  i_in,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_status              o_st,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out
);

    localparam int AW  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IBM = $clog2(SETS + 1) - 1;
    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LV  = $clog2(WAYS + 1) - 1;
    localparam int PTW = (WAYS > 1) ? WAYS - 1 : 1;
    localparam int LW  = $clog2(WAYS);
    // Reciprocal of WAYS, rounded up, so that the quotient of any 32-bit draw
    // comes out exactly from one multiplication and a shift.
    localparam logic [63:0] RECIP = ((64'd1 << (32 + LW)) / 64'(WAYS)) + 64'd1;

    typedef struct packed {
        logic [WAYS-1:0][AW-1:0] tag;
        logic [WAYS-1:0][63:0]   stamp;
        logic [WAYS-1:0][1:0]    lvl;
        logic [WAYS-1:0]         valid;
        logic [WAYS-1:0]         dirty;
        logic [PTW-1:0]          plru;
    } t_row;

    function automatic logic [WW-1:0] plru_pick(input logic [PTW-1:0] t);
        int node;
        int way;
        node = 0;
        way  = 0;
        for (int k = 0; k < LV; k++) begin
            if (t[node]) begin
                way  = way + (WAYS >> (k + 1));
                node = 2 * node + 2;
            end else begin
                node = 2 * node + 1;
            end
        end
        return (way < WAYS) ? WW'(way) : WW'(WAYS - 1);
    endfunction

    function automatic logic [PTW-1:0] plru_touch(input logic [PTW-1:0] t,
                                                  input logic [WW-1:0] way);
        logic [PTW-1:0] b;
        int node;
        int start;
        int size;
        int mid;
        b     = t;
        node  = 0;
        start = 0;
        size  = WAYS;
        for (int k = 0; k < LV; k++) begin
            mid = start + size / 2;
            if (int'(way) < mid) begin
                b[node] = 1'b1;
                node    = 2 * node + 1;
            end else begin
                b[node] = 1'b0;
                start   = mid;
                node    = 2 * node + 2;
            end
            size = size / 2;
        end
        return b;
    endfunction

    // Configuration and persistent state.
    logic [2:0]      r_pol;
    logic [3:0]      r_off;
    logic [2:0]      r_sib;
    logic [31:0]     r_lfsr;
    logic [63:0]     r_acc;
    logic [SETS-1:0] r_row_ok;
    logic            r_ovalid;

    // Request and working registers.
    t_in             r_req;
    t_row            m_mem [SETS];
    t_row            r_rd;
    logic            r_rd_ok;
    logic [WW-1:0]   r_best;
    logic [WW-1:0]   r_rem;
    logic [31:0]     r_div;
    logic [31:0]     r_quo;
    t_out            r_out;

    logic [4:0]      ib;
    logic [4:0]      tshift;
    logic [AW-1:0]   addr;
    logic [AW-1:0]   shifted;
    logic [SW-1:0]   set_idx;
    logic [AW-1:0]   req_tag;
    t_row            rd;
    logic            found;
    logic [WW-1:0]   hw;
    logic            any_inv;
    logic [WW-1:0]   inv_way;
    logic [1:0]      top;
    logic [WAYS-1:0][1:0] aged;
    logic [WW-1:0]   rrip_way;
    logic            acc_op;
    logic            is_rrip;
    logic [WW-1:0]   v;
    logic [31:0]     step_lfsr;
    logic [64:0]     prod;
    logic [31:0]     quo;
    logic [31:0]     rem_full;
    t_row            n_row;
    t_out            n_out;

    assign ib = ({2'b00, r_sib} < 5'(IBM)) ? {2'b00, r_sib} : 5'(IBM);
    assign tshift  = {1'b0, r_off} + ib;
    assign addr    = r_req.address[AW-1:0];
    assign shifted = addr >> r_off;
    assign set_idx = SW'(shifted) & ~({SW{1'b1}} << ib);
    assign req_tag = addr >> tshift;
    assign rd      = r_rd_ok ? r_rd : '0;
    assign acc_op  = (r_req.opcode == OP_ACCESS) || (r_req.opcode == OP_INSTALL);
    assign is_rrip = (r_pol == POL_SRRIP) || (r_pol == POL_BRRIP);
    assign step_lfsr = lfsr_step(r_lfsr);

    // The random victim is the draw modulo WAYS: the quotient is registered in
    // the first step, the remainder is formed in the second.
    assign prod     = 65'(r_div) * 65'(RECIP[32:0]);
    assign quo      = 32'(prod >> (32 + LW));
    assign rem_full = r_div - (r_quo * 32'(WAYS));

    always_comb begin
        found   = 1'b0;
        hw      = '0;
        any_inv = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rd.valid[w] && (rd.tag[w] == req_tag)) begin
                found = 1'b1;
                hw    = WW'(w);
            end
            if (!rd.valid[w]) begin
                any_inv = 1'b1;
                inv_way = WW'(w);
            end
        end
    end

    // Aging lifts every level by the same amount until the highest reaches the maximum.
    always_comb begin
        top      = '0;
        rrip_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (rd.lvl[w] > top) begin
                top = rd.lvl[w];
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            aged[w] = rd.lvl[w] + (RRIP_MAX - top);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (aged[w] == RRIP_MAX) begin
                rrip_way = WW'(w);
            end
        end
    end

    always_comb begin
        if (any_inv) begin
            v = inv_way;
        end else begin
            case (r_pol)
                POL_PLRU:             v = plru_pick(rd.plru);
                POL_RAND:             v = r_rem;
                POL_SRRIP, POL_BRRIP: v = rrip_way;
                default:              v = r_best;
            endcase
        end
    end

    always_comb begin
        n_row = rd;
        n_out = '0;
        n_out.outcome    = found ? RES_HIT : RES_MISS;
        n_out.line_found = found;
        case (r_req.opcode) inside
            OP_ACCESS, OP_INSTALL: begin
                if (found) begin
                    n_row.stamp[hw] = r_acc + 64'd1;
                    if (is_rrip) begin
                        n_row.lvl[hw] = '0;
                    end
                    if (r_pol == POL_PLRU) begin
                        n_row.plru = plru_touch(rd.plru, hw);
                    end
                    if (r_req.write_flag) begin
                        n_row.dirty[hw] = 1'b1;
                    end
                end else begin
                    if (rd.valid[v] && rd.dirty[v]) begin
                        n_out.outcome         = RES_MISS_DIRTY;
                        n_out.dirty_seen      = 1'b1;
                        n_out.evicted_address = (ADDR_W'(rd.tag[v]) << tshift)
                                              | (ADDR_W'(set_idx) << r_off);
                    end
                    if (is_rrip && !any_inv) begin
                        n_row.lvl = aged;
                    end
                    n_row.tag[v]   = req_tag;
                    n_row.valid[v] = 1'b1;
                    n_row.dirty[v] = r_req.write_flag;
                    n_row.stamp[v] = r_acc + 64'd1;
                    if (r_pol == POL_SRRIP) begin
                        n_row.lvl[v] = RRIP_LONG;
                    end else if (r_pol == POL_BRRIP) begin
                        n_row.lvl[v] = (step_lfsr[4:0] == BRRIP_MASK_ZERO)
                                     ? RRIP_LONG : RRIP_MAX;
                    end
                    if (r_pol == POL_PLRU) begin
                        n_row.plru = plru_touch(rd.plru, v);
                    end
                end
            end
            OP_INVAL: begin
                if (found) begin
                    n_row.valid[hw] = 1'b0;
                    n_row.dirty[hw] = 1'b0;
                end
            end
            OP_CLEAN: begin
                if (found) begin
                    n_out.dirty_seen = rd.dirty[hw];
                    n_row.dirty[hw]  = 1'b0;
                end
            end
            default: begin
                if (found) begin
                    n_out.dirty_seen = rd.dirty[hw];
                end
            end
        endcase
    end

    always_comb begin
        o_st.need_mod  = acc_op && !found && !any_inv && (r_pol == POL_RAND);
        o_st.need_scan = acc_op && !found && !any_inv && (WAYS > 1)
                       && !((r_pol == POL_PLRU) || (r_pol == POL_RAND)
                            || (r_pol == POL_SRRIP) || (r_pol == POL_BRRIP));
        o_st.out_free  = !r_ovalid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol    <= POL_LRU;
            r_off    <= 4'd6;
            r_sib    <= 3'd6;
            r_lfsr   <= 32'd1;
            r_acc    <= '0;
            r_row_ok <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POLICY: r_pol <= i_cfg_data[2:0];
                    CFG_OFFSET: r_off <= i_cfg_data[3:0];
                    CFG_INDEX:  r_sib <= i_cfg_data[2:0];
                    CFG_SEED:   r_lfsr <= (i_cfg_data == '0) ? 32'd1 : i_cfg_data;
                    default:    r_pol <= r_pol;
                endcase
            end
            if (i_cmd.look && o_st.need_mod) begin
                r_lfsr <= step_lfsr;
            end
            if (i_cmd.commit) begin
                if (acc_op) begin
                    r_acc <= r_acc + 64'd1;
                    if (!found && (r_pol == POL_BRRIP)) begin
                        r_lfsr <= step_lfsr;
                    end
                end
                r_row_ok[set_idx] <= 1'b1;
                r_ovalid          <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in;
        end
        if (i_cmd.read) begin
            r_rd    <= m_mem[set_idx];
            r_rd_ok <= r_row_ok[set_idx];
        end
        if (i_cmd.look) begin
            r_best <= '0;
            r_rem  <= '0;
            r_div  <= step_lfsr;
        end
        if (i_cmd.scan) begin
            if (rd.stamp[i_cmd.idx[WW-1:0]] < rd.stamp[r_best]) begin
                r_best <= i_cmd.idx[WW-1:0];
            end
        end
        if (i_cmd.modstep) begin
            if (i_cmd.idx == '0) begin
                r_quo <= quo;
            end else begin
                r_rem <= rem_full[WW-1:0];
            end
        end
        if (i_cmd.commit) begin
            m_mem[set_idx] <= n_row;
            r_out          <= n_out;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

@@ sv/set_assoc_cache_tag_replacement_top.sv @@
// Write-back set-associative tag array with selectable replacement policy.
// Requests arrive on the input channel (i_in_valid / o_in_ready, payload i_in)
// and each one produces exactly one result transfer on the output channel
// (o_out_valid / i_out_ready, payload o_out).
// One request is in flight at a time. A request passes through four states
// (accept, set read, tag compare, row write-back), and its result is registered
// at the row write-back. A miss on a full set adds a serial timestamp scan under
// LRU, and under the random policy a quotient step and a remainder step that
// reduce the LFSR draw modulo WAYS by a reciprocal multiplication.
// The result sits in an output register, so a stalled receiver does not block
// the next request from being accepted and looked up; only its write-back waits
// until the output register is free.
// Reset clears the configuration to its defaults, the LFSR to one, the access
// counter, and a valid flag per set, so every set reads as empty straight away
// with no clearing pass. Configuration writes are taken in any cycle but are
// only meaningful while the block is idle.
module set_assoc_cache_tag_replacement_top import sact_pkg::*; #(
    parameter int SETS      = 64,
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    // The controller sequences each request through read, compare, an optional
    // victim search, and commit.
    sact_ctrl #(
        .WAYS(WAYS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // The datapath holds the set memory, configuration, LFSR and result register.
    sact_dp #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

@@ sv/sact_checker.sv @@
module sact_checker import sact_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // A stalled result must hold still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Only one request is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    // A hit is reported exactly when a matching line was present.
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.outcome == RES_HIT) == o_out.line_found))
        else $error("outcome and line_found disagree");

    // A victim address is only reported with a dirty eviction.
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.evicted_address != '0)
            |-> (o_out.outcome == RES_MISS_DIRTY) && o_out.dirty_seen)
        else $error("evicted address without dirty eviction");

endmodule

bind set_assoc_cache_tag_replacement_top sact_checker u_chk (.*);
